FILE: sv/bdqs_pkg.sv
// Shared types and constants for the bounded deque with search.
// Used by bdqs_ctrl and by the bounded_deque_with_search_core top level.
package bdqs_pkg;

  // fixed widths of the request fields
  localparam int unsigned FuncW    = 3;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned InTdataW = 40;

  // requested operation
  typedef enum logic [FuncW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // result flags passed from the controller to the output stage
  typedef struct packed {
    status_e status;
    logic    found;
    logic    empty;
  } res_flags_t;

endpackage

FILE: sv/bdqs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bdqs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port, read data holds without a read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/bdqs_ctrl.sv
// Sequencer of the deque: head pointer, entry count, push/pop updates and the
// search scan over the entry RAM. Depends on bdqs_pkg; drives one bdqs_ram.
module bdqs_ctrl
  import bdqs_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request side
  input  logic                             req_valid_i,
  output logic                             req_ready_o,
  input  logic [FuncW-1:0]                 req_func_i,
  input  logic [DATA_WIDTH-1:0]            req_value_i,
  // result side
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output res_flags_t                       res_flags_o,
  output logic [$clog2(DEPTH+1)-1:0]       res_count_o,
  // entry RAM
  output logic                             ram_we_o,
  output logic [$clog2(DEPTH)-1:0]         ram_waddr_o,
  output logic [DATA_WIDTH-1:0]            ram_wdata_o,
  output logic                             ram_re_o,
  output logic [$clog2(DEPTH)-1:0]         ram_raddr_o,
  input  logic [DATA_WIDTH-1:0]            ram_rdata_i
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  // circular index of base + off, both below DEPTH
  function automatic logic [IdxW-1:0] wrap_add(input logic [IdxW-1:0] base,
                                               input logic [CntW-1:0] off);
    logic [SumW-1:0] sum;
    sum = SumW'(base) + SumW'(off);
    if (sum >= SumW'(DEPTH)) begin
      sum = sum - SumW'(DEPTH);
    end
    return sum[IdxW-1:0];
  endfunction

  state_e          state_q, state_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DATA_WIDTH-1:0] key_q, key_d;
  logic [CntW-1:0] iss_q, iss_d;
  logic            rd_vld_q, rd_vld_d;
  logic            rd_last_q, rd_last_d;
  logic            res_vld_q, res_vld_d;
  res_flags_t      res_flags_q, res_flags_d;
  logic [CntW-1:0] res_cnt_q, res_cnt_d;

  logic            accept;
  logic            res_free;
  logic            full;
  logic            empty;
  logic [IdxW-1:0] head_dec;
  logic [IdxW-1:0] head_inc;
  logic            hit;
  logic            fin;
  logic            fin_found;
  status_e         fin_status;

  assign res_free    = !res_vld_q || res_ready_i;
  assign req_ready_o = (state_q == S_IDLE) && res_free;
  assign accept      = req_valid_i && req_ready_o;
  assign full        = (cnt_q == CntW'(DEPTH));
  assign empty       = (cnt_q == '0);
  assign head_dec    = (head_q == '0) ? IdxW'(DEPTH - 1) : head_q - IdxW'(1);
  assign head_inc    = (head_q == IdxW'(DEPTH - 1)) ? '0 : head_q + IdxW'(1);
  assign hit         = rd_vld_q && (ram_rdata_i == key_q);

  // next-state logic for pointers, scan and result register
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    key_d       = key_q;
    iss_d       = iss_q;
    rd_vld_d    = rd_vld_q;
    rd_last_d   = rd_last_q;
    res_vld_d   = res_vld_q;
    res_flags_d = res_flags_q;
    res_cnt_d   = res_cnt_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = head_dec;
    ram_wdata_o = req_value_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = wrap_add(head_q, iss_q);
    fin         = 1'b0;
    fin_found   = 1'b0;
    fin_status  = ST_OK;

    // result handed to the output stage
    if (res_vld_q && res_ready_i) begin
      res_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          fin = 1'b1;
          case (op_e'(req_func_i))
            OP_PUSH_FRONT: begin
              if (full) begin
                fin_status = ST_FULL;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = head_dec;
                head_d      = head_dec;
                cnt_d       = cnt_q + CntW'(1);
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                fin_status = ST_FULL;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = wrap_add(head_q, cnt_q);
                cnt_d       = cnt_q + CntW'(1);
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                fin_status = ST_EMPTY;
              end else begin
                head_d = head_inc;
                cnt_d  = cnt_q - CntW'(1);
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                fin_status = ST_EMPTY;
              end else begin
                cnt_d = cnt_q - CntW'(1);
              end
            end
            OP_SEARCH: begin
              // an empty queue answers at once, otherwise start the scan
              if (!empty) begin
                fin      = 1'b0;
                key_d    = req_value_i;
                iss_d    = '0;
                rd_vld_d = 1'b0;
                state_d  = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rd_vld_q && (hit || rd_last_q)) begin
          // decision made, wait for room in the result register
          if (res_free) begin
            fin       = 1'b1;
            fin_found = hit;
            rd_vld_d  = 1'b0;
            state_d   = S_IDLE;
          end
        end else begin
          // read the next entry from front to back
          ram_re_o  = 1'b1;
          iss_d     = iss_q + CntW'(1);
          rd_vld_d  = 1'b1;
          rd_last_d = ((iss_q + CntW'(1)) == cnt_q);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // load the result of the finished request
    if (fin) begin
      res_vld_d          = 1'b1;
      res_flags_d.status = fin_status;
      res_flags_d.found  = fin_found;
      res_flags_d.empty  = (cnt_d == '0);
      res_cnt_d          = cnt_d;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      cnt_q       <= '0;
      key_q       <= '0;
      iss_q       <= '0;
      rd_vld_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      res_vld_q   <= 1'b0;
      res_flags_q <= '0;
      res_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      key_q       <= key_d;
      iss_q       <= iss_d;
      rd_vld_q    <= rd_vld_d;
      rd_last_q   <= rd_last_d;
      res_vld_q   <= res_vld_d;
      res_flags_q <= res_flags_d;
      res_cnt_q   <= res_cnt_d;
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_flags_o = res_flags_q;
  assign res_count_o = res_cnt_q;

endmodule

FILE: sv/bounded_deque_with_search_core.sv
// Top level of the bounded deque with search: stream ports, output register.
// Depends on bdqs_pkg, bdqs_ctrl and bdqs_ram.
//
// A bounded double-ended queue of DEPTH words held in one synchronous RAM as a
// circular buffer. Each request pushes or pops at either end or searches for a
// value, and gives exactly one result with status, found flag, entry count
// and empty flag. Push, pop, an unknown operation and a search on an empty
// queue need no scan, so such requests pass at one per cycle while results
// are taken. In a search with n entries held, the entries are read one per
// cycle, front to back, through the single read port of the RAM,
// and the scan stops early on the first match. No request is taken during a
// scan. The RAM needs no clearing after reset. A result waits in an output
// register while the next request is taken.
module bounded_deque_with_search_core
  import bdqs_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned CntW      = $clog2(DEPTH + 1),
  localparam int unsigned OutTdataW = ((4 + CntW + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,  // func[2:0], value[34:3], zero pad
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata   // status, found, count, empty_res, pad
);

  localparam int unsigned IdxW = $clog2(DEPTH);

  logic [FuncW-1:0]      req_func;
  logic [ValueW-1:0]     req_value;
  logic [DATA_WIDTH-1:0] req_data;

  logic                  res_valid;
  logic                  res_ready;
  res_flags_t            res_flags;
  logic [CntW-1:0]       res_count;

  logic                  ram_we;
  logic [IdxW-1:0]       ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [IdxW-1:0]       ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic                  out_vld_q;
  res_flags_t            out_flags_q;
  logic [CntW-1:0]       out_cnt_q;

  // unpack the request
  assign req_func  = s_axis_tdata[FuncW-1:0];
  assign req_value = s_axis_tdata[FuncW+ValueW-1:FuncW];

  // fit the request value to the stored word width
  if (DATA_WIDTH > ValueW) begin : g_val_ext
    assign req_data = {{(DATA_WIDTH - ValueW){1'b0}}, req_value};
  end else if (DATA_WIDTH == ValueW) begin : g_val_eq
    assign req_data = req_value;
  end else begin : g_val_trunc
    assign req_data = req_value[DATA_WIDTH-1:0];
  end

  bdqs_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_func_i  (req_func),
    .req_value_i (req_data),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_flags_o (res_flags),
    .res_count_o (res_count),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  bdqs_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register, refilled when empty or being taken
  assign res_ready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_flags_q <= res_flags;
      out_cnt_q   <= res_count;
    end
  end

  // pack the result
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OutTdataW'({out_flags_q.empty, out_cnt_q, out_flags_q.found,
                                     out_flags_q.status});

  // count never exceeds the capacity
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_cnt_q <= CntW'(DEPTH)))
    else $error("result count above capacity");

  // empty flag agrees with the count
  a_empty_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_flags_q.empty == (out_cnt_q == '0)))
    else $error("empty flag and count disagree");

  // a match comes only with ok status and leaves the count nonzero
  a_found_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_flags_q.found) |-> (out_flags_q.status == ST_OK && !out_flags_q.empty))
    else $error("found set on a failed or empty result");

  // a held result keeps its count while stalled
  a_res_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |=> (out_vld_q && $stable(out_cnt_q)))
    else $error("stalled result changed");

endmodule

FILE: bench/bounded_deque_with_search_core_tb.sv
// Self-checking testbench for bounded_deque_with_search_core.
// Needs bdqs_pkg and the core RTL; drives requests, checks every result
// against a behavioral deque predictor kept inside the bench.
`timescale 1ns / 1ps

module bounded_deque_with_search_core_tb
  import bdqs_pkg::*;
();

  localparam int unsigned Depth = 16;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned OutW  = ((4 + CntW + 7) / 8) * 8;

  // func codes past the last defined operation
  localparam logic [FuncW-1:0] FuncUnusedLo = OP_SEARCH + 1'b1;
  localparam logic [FuncW-1:0] FuncUnusedHi = '1;

  typedef struct {
    logic [FuncW-1:0]  func;
    logic [ValueW-1:0] value;
    bit                settle;  // hold off until every reply is back
  } deque_req_t;

  typedef struct packed {
    status_e         status;
    logic            found;
    logic [CntW-1:0] count;
    logic            empty;
  } deque_reply_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InTdataW-1:0] s_axis_tdata  = '0;  // func, value, zero pad
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutW-1:0]     m_axis_tdata;        // status, found, count, empty_res, pad

  deque_req_t   queued_requests[$];
  deque_reply_t deque_replies_due[$];

  // predicted deque contents
  logic [ValueW-1:0] slot_word [Depth];
  logic [PtrW-1:0]   front_ptr = '0;
  logic [CntW-1:0]   held      = '0;

  int unsigned reqs_taken  = 0;
  int unsigned fault_count = 0;
  int unsigned send_gap    = 0;
  int unsigned stall_left  = 0;

  bounded_deque_with_search_core #(
    .DEPTH      (Depth),
    .DATA_WIDTH (ValueW)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // apply one request to the predicted deque and return its reply
  function automatic deque_reply_t deque_step(logic [FuncW-1:0] func,
                                              logic [ValueW-1:0] value);
    deque_reply_t r;
    int unsigned  i;
    r.status = ST_OK;
    r.found  = 1'b0;
    case (func)
      OP_PUSH_FRONT: begin
        if (held == Depth) begin
          r.status = ST_FULL;
        end else begin
          front_ptr = front_ptr - 1'b1;
          slot_word[front_ptr] = value;
          held = held + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (held == Depth) begin
          r.status = ST_FULL;
        end else begin
          slot_word[PtrW'(front_ptr + held)] = value;
          held = held + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          front_ptr = front_ptr + 1'b1;
          held = held - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (held == 0) r.status = ST_EMPTY;
        else held = held - 1'b1;
      end
      OP_SEARCH: begin
        for (i = 0; i < held; i++) begin
          if (slot_word[PtrW'(front_ptr + i)] == value) begin
            r.found = 1'b1;
            break;
          end
        end
      end
      default: ;
    endcase
    r.count = held;
    r.empty = (held == 0);
    return r;
  endfunction

  // idling only early in the run, with quiet stretches in between
  function automatic bit may_idle();
    return (queued_requests.size() > 150) && ((reqs_taken / 100) % 4 != 3);
  endfunction

  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return ValueW'($urandom_range(0, 3));
      1:       return '1 - ValueW'($urandom_range(0, 3));
      default: return ValueW'($urandom);
    endcase
  endfunction

  task automatic add_req(logic [FuncW-1:0] func, logic [ValueW-1:0] value,
                         bit settle = 1'b0);
    deque_req_t q;
    q.func   = func;
    q.value  = value;
    q.settle = settle;
    queued_requests.push_back(q);
  endtask

  // directed corners, then random phases that fill, drain and search
  task automatic build_requests();
    logic [ValueW-1:0] recent[$];
    logic [ValueW-1:0] v;
    int                est;
    int                mode;
    int                seg_left;
    int                roll;
    int                push_pct;
    int unsigned       n;
    // empty queue corners and unused codes
    add_req(OP_SEARCH, '0);
    add_req(OP_POP_FRONT, '1);
    add_req(OP_POP_BACK, '0);
    add_req(FuncUnusedLo, '1);
    add_req(FuncUnusedHi, '0);
    add_req(OP_PUSH_BACK, '1);
    add_req(OP_POP_BACK, '1);
    // fill from both ends, then push on full at both ends
    for (n = 0; n < Depth; n++) begin
      if (n == Depth - 1) v = 32'hFFFF_FFFE;
      else if (n == 0) v = '0;
      else if (n == 1) v = '1;
      else v = ValueW'($urandom);
      add_req(n[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, v);
    end
    add_req(OP_PUSH_FRONT, 32'h1234_5678, 1'b1);
    add_req(OP_PUSH_BACK, 32'h8765_4321);
    // last back entry sits at the far end of the scan
    add_req(OP_SEARCH, 32'hFFFF_FFFE);

    est      = Depth;
    mode     = 0;
    seg_left = 0;
    for (n = 0; n < 1450; n++) begin
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 3);
        seg_left = $urandom_range(20, 60);
      end
      seg_left--;
      case (mode)
        0:       push_pct = 75;
        1:       push_pct = 25;
        default: push_pct = 50;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        add_req(FuncUnusedLo + FuncW'($urandom_range(0, 2)), pick_value());
      end else if (roll < ((mode == 3) ? 50 : 25)) begin
        if (recent.size() != 0 && $urandom_range(0, 9) < 6)
          v = recent[$urandom_range(0, recent.size() - 1)];
        else
          v = pick_value();
        add_req(OP_SEARCH, v, (n % 300) == 299);
      end else if ($urandom_range(0, 99) < push_pct) begin
        v = pick_value();
        add_req($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, v,
                (n % 300) == 299);
        recent.push_back(v);
        if (recent.size() > 12) void'(recent.pop_front());
        if (est < Depth) est++;
      end else begin
        add_req($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, pick_value(),
                (n % 300) == 299);
        if (est > 0) est--;
      end
      // steer back from the ends now and then
      if (est == Depth && mode == 0 && $urandom_range(0, 3) == 0) seg_left = 0;
      if (est == 0 && mode == 1 && $urandom_range(0, 3) == 0) seg_left = 0;
    end
  endtask

  task automatic check_reply(logic [OutW-1:0] word);
    deque_reply_t got;
    deque_reply_t want;
    got.status = status_e'(word[1:0]);
    got.found  = word[2];
    got.count  = word[3 +: CntW];
    got.empty  = word[3 + CntW];
    if (deque_replies_due.size() == 0) begin
      fault_count++;
      if (fault_count <= 10)
        $display("%0t: result with no request waiting: %h", $time, word);
    end else begin
      want = deque_replies_due.pop_front();
      if (got.status !== want.status || got.found !== want.found ||
          got.count !== want.count || got.empty !== want.empty) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: expected status %0d found %0d count %0d empty %0d, got %0d %0d %0d %0d",
                   $time, want.status, want.found, want.count, want.empty,
                   got.status, got.found, got.count, got.empty);
      end
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    deque_req_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_gap      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        deque_replies_due.push_back(deque_step(s_axis_tdata[FuncW-1:0],
                                               s_axis_tdata[FuncW +: ValueW]));
        reqs_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap      <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (queued_requests.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (queued_requests[0].settle && deque_replies_due.size() != 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (may_idle() && $urandom_range(0, 7) == 0) begin
          send_gap      <= $urandom_range(0, 5);
          s_axis_tvalid <= 1'b0;
        end else begin
          nxt = queued_requests.pop_front();
          s_axis_tdata  <= {{(InTdataW - FuncW - ValueW){1'b0}}, nxt.value, nxt.func};
          s_axis_tvalid <= 1'b1;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_reply(m_axis_tdata);
      if (stall_left != 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (may_idle() && $urandom_range(0, 5) == 0) begin
        stall_left    <= $urandom_range(0, 5);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    build_requests();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (queued_requests.size() != 0 || s_axis_tvalid || deque_replies_due.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fault_count == 0 && deque_replies_due.size() == 0) begin
      $display("bounded_deque_with_search_core test passed");
    end else begin
      $display("bounded_deque_with_search_core test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("bounded_deque_with_search_core test failed");
    $finish;
  end

endmodule
